// ===== hw/rtl/spi_link_burst_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// spi link burst sequencer assertion macros
// shared property forms for the sequencer checks, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef SPI_LINK_BURST_SEQUENCER_ASSERT_SVH
`define SPI_LINK_BURST_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define SLBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/slbs_pkg.sv =====
// ----------------------------------------------------------------------------
// slbs_pkg
// shared types, constants and helpers of the spi link burst sequencer
// ----------------------------------------------------------------------------
package slbs_pkg;

    // frame overheads and buffer limit
    localparam int CMD_BYTES    = 4;
    localparam int IND_BYTES    = 4;
    localparam int BUFFER_BYTES = 8192;

    // field widths
    localparam int WORD_W  = 16;
    localparam int DMA_W   = 17;
    localparam int ALIGN_W = 5;

    // remainder unit: digits of DIGIT_BITS bits over a padded dividend
    localparam int DIGIT_BITS = 6;
    localparam int DIV_STEPS  = (DMA_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int DIV_W      = DIV_STEPS * DIGIT_BITS;
    localparam int STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // stream widths
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_FIELDS_W = 2 * WORD_W + 2 * DMA_W + 2 * WORD_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int OUT_TUSER_W  = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ALIGN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CODE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_CODE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INDICATION_CODE = 3'd4;

    // configuration reset values
    localparam logic [ALIGN_W-1:0] FRAME_ALIGN_RST     = 5'd2;
    localparam logic [WORD_W-1:0]  WRITE_CODE_RST      = 16'd0;
    localparam logic [WORD_W-1:0]  READ_CODE_RST       = 16'd1;
    localparam logic [WORD_W-1:0]  END_CODE_RST        = 16'd2;
    localparam logic [WORD_W-1:0]  INDICATION_CODE_RST = 16'd4;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
    } dp_status_t;

    // one digit group of a restoring remainder, align in 1..31
    function automatic logic [ALIGN_W-1:0] rem_digits(
        input logic [ALIGN_W-1:0]    rem,
        input logic [DIGIT_BITS-1:0] bits,
        input logic [ALIGN_W-1:0]    align
    );
        logic [ALIGN_W:0]   r6;
        logic [ALIGN_W-1:0] r;
        r = rem;
        for (int i = DIGIT_BITS - 1; i >= 0; i--)
        begin
            r6 = {r, bits[i]};
            if (r6 >= {1'b0, align})
            begin
                r6 = r6 - {1'b0, align};
            end
            r = r6[ALIGN_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/slbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// slbs_ctrl
// burst sequencing state machine and result handshake
// ----------------------------------------------------------------------------
module slbs_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  slbs_pkg::dp_status_t  status,
    output slbs_pkg::dp_cmd_t     cmd
);

    slbs_pkg::state_t state_reg;
    slbs_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == slbs_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            slbs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = slbs_pkg::ST_DIV;
                end
            end
            slbs_pkg::ST_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = slbs_pkg::ST_FIN;
                end
            end
            slbs_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = slbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slbs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`include "spi_link_burst_sequencer_assert.svh"

    `SLBS_ASSERT_NOW(a_load_when_free, cmd.load, !out_valid_reg || m_tready, "result overwritten")
    `SLBS_ASSERT_NEXT(a_start_to_div, cmd.start, state_reg == slbs_pkg::ST_DIV, "start lost")
    `SLBS_ASSERT_NEXT(a_last_to_fin, cmd.step && status.div_last, state_reg == slbs_pkg::ST_FIN, "remainder not finished")
    `SLBS_ASSERT_NOW(a_cmd_exclusive, cmd.start, !cmd.step && !cmd.load, "commands overlap")

endmodule

// ===== hw/rtl/slbs_datapath.sv =====
// ----------------------------------------------------------------------------
// slbs_datapath
// command choice, link state, configuration and dma length padding
// ----------------------------------------------------------------------------
module slbs_datapath
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [slbs_pkg::IN_TDATA_W-1:0]         s_tdata,
    input  logic                                    cfg_valid,
    input  logic [slbs_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [slbs_pkg::WORD_W-1:0]             cfg_data,
    input  slbs_pkg::dp_cmd_t                       cmd,
    output slbs_pkg::dp_status_t                    status,
    output logic [slbs_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic [slbs_pkg::OUT_TUSER_W-1:0]        m_tuser,
    output logic                                    m_tlast
);

    localparam int W  = slbs_pkg::WORD_W;
    localparam int DW = slbs_pkg::DMA_W;
    localparam int AW = slbs_pkg::ALIGN_W;

    // configuration
    logic [AW-1:0] frame_align_reg;
    logic [W-1:0]  write_code_reg;
    logic [W-1:0]  read_code_reg;
    logic [W-1:0]  end_code_reg;
    logic [W-1:0]  indication_code_reg;

    // link state
    logic          closed_reg;
    logic          owed_reg;
    logic [W-1:0]  tx_committed_reg;
    logic [W-1:0]  rx_committed_reg;
    logic [W-1:0]  rx_announced_reg;

    // burst work registers
    logic [W-1:0]  cmd_word_reg;
    logic [W-1:0]  len_word_reg;
    logic [W-1:0]  tx_frame_reg;
    logic [W-1:0]  rx_frame_reg;
    logic [DW-1:0] tx_total_reg;
    logic [DW-1:0] rx_total_reg;
    logic [AW-1:0] align_reg;
    logic          first_reg;
    logic          eot_reg;
    logic          tx_err_reg;
    logic          ind_err_reg;
    logic          rx_err_reg;

    // remainder unit
    logic [slbs_pkg::DIV_W-1:0]      tx_shift_reg;
    logic [slbs_pkg::DIV_W-1:0]      rx_shift_reg;
    logic [AW-1:0]                   tx_rem_reg;
    logic [AW-1:0]                   rx_rem_reg;
    logic [slbs_pkg::STEP_CNT_W-1:0] step_cnt_reg;

    // result registers
    logic [W-1:0]  o_cmd_reg;
    logic [W-1:0]  o_len_reg;
    logic [DW-1:0] o_tx_dma_reg;
    logic [DW-1:0] o_rx_dma_reg;
    logic [W-1:0]  o_tx_frame_reg;
    logic [W-1:0]  o_rx_frame_reg;
    logic          o_first_reg;
    logic          o_eot_reg;
    logic          o_tx_err_reg;
    logic          o_ind_err_reg;
    logic          o_rx_err_reg;

    logic [W-1:0]  tx_next_len;
    logic [W-1:0]  slave_cmd;
    logic [W-1:0]  slave_len;
    logic          owed_eff;
    logic [W-1:0]  cmd_word_next;
    logic          eot_next;
    logic          owed_next;
    logic [DW-1:0] tx_total_next;
    logic [DW-1:0] rx_total_next;
    logic [AW-1:0] align_next;
    logic [AW-1:0] tx_pad;
    logic [AW-1:0] rx_pad;
    logic [DW-1:0] tx_dma_next;
    logic [DW-1:0] rx_dma_next;

    assign tx_next_len = s_tdata[W-1:0];
    assign slave_cmd   = s_tdata[2*W-1:W];
    assign slave_len   = s_tdata[3*W-1:2*W];

    // trailing command choice
    always_comb
    begin
        owed_eff = closed_reg || owed_reg;
        eot_next = 1'b0;
        if (tx_next_len != '0)
        begin
            cmd_word_next = write_code_reg;
            owed_next     = 1'b1;
        end
        else if ((rx_announced_reg != '0) || owed_eff)
        begin
            cmd_word_next = read_code_reg;
            owed_next     = 1'b0;
        end
        else
        begin
            cmd_word_next = end_code_reg;
            owed_next     = 1'b0;
            eot_next      = 1'b1;
        end
    end

    assign tx_total_next = {1'b0, tx_committed_reg} + DW'(slbs_pkg::CMD_BYTES);
    assign rx_total_next = {1'b0, rx_committed_reg} + DW'(slbs_pkg::IND_BYTES);
    assign align_next    = (frame_align_reg == '0) ? AW'(1) : frame_align_reg;

    // round up only when a frame is carried
    assign tx_pad = ((tx_frame_reg != '0) && (tx_rem_reg != '0)) ? (align_reg - tx_rem_reg) : '0;
    assign rx_pad = ((rx_frame_reg != '0) && (rx_rem_reg != '0)) ? (align_reg - rx_rem_reg) : '0;
    assign tx_dma_next = tx_total_reg + {{(DW-AW){1'b0}}, tx_pad};
    assign rx_dma_next = rx_total_reg + {{(DW-AW){1'b0}}, rx_pad};

    assign status.div_last = (step_cnt_reg == slbs_pkg::STEP_CNT_W'(slbs_pkg::DIV_STEPS - 1));

    // configuration and link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_align_reg     <= slbs_pkg::FRAME_ALIGN_RST;
            write_code_reg      <= slbs_pkg::WRITE_CODE_RST;
            read_code_reg       <= slbs_pkg::READ_CODE_RST;
            end_code_reg        <= slbs_pkg::END_CODE_RST;
            indication_code_reg <= slbs_pkg::INDICATION_CODE_RST;
            closed_reg          <= 1'b1;
            owed_reg            <= 1'b1;
            tx_committed_reg    <= '0;
            rx_committed_reg    <= '0;
            rx_announced_reg    <= '0;
            step_cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    slbs_pkg::CFG_FRAME_ALIGN:     frame_align_reg     <= cfg_data[AW-1:0];
                    slbs_pkg::CFG_WRITE_CODE:      write_code_reg      <= cfg_data;
                    slbs_pkg::CFG_READ_CODE:       read_code_reg       <= cfg_data;
                    slbs_pkg::CFG_END_CODE:        end_code_reg        <= cfg_data;
                    slbs_pkg::CFG_INDICATION_CODE: indication_code_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.start)
            begin
                closed_reg       <= eot_next;
                owed_reg         <= owed_next;
                rx_announced_reg <= slave_len;
                tx_committed_reg <= eot_next ? '0 : tx_next_len;
                rx_committed_reg <= eot_next ? '0 : slave_len;
                step_cnt_reg     <= '0;
            end
            else if (cmd.step)
            begin
                step_cnt_reg <= step_cnt_reg + slbs_pkg::STEP_CNT_W'(1);
            end
        end
    end

    // burst work and remainder digits
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cmd_word_reg <= cmd_word_next;
            len_word_reg <= tx_next_len;
            tx_frame_reg <= tx_committed_reg;
            rx_frame_reg <= rx_committed_reg;
            tx_total_reg <= tx_total_next;
            rx_total_reg <= rx_total_next;
            align_reg    <= align_next;
            first_reg    <= closed_reg;
            eot_reg      <= eot_next;
            tx_err_reg   <= (tx_next_len > W'(slbs_pkg::BUFFER_BYTES));
            ind_err_reg  <= (slave_cmd != indication_code_reg);
            rx_err_reg   <= (rx_committed_reg > W'(slbs_pkg::BUFFER_BYTES));
            tx_shift_reg <= slbs_pkg::DIV_W'(tx_total_next);
            rx_shift_reg <= slbs_pkg::DIV_W'(rx_total_next);
            tx_rem_reg   <= '0;
            rx_rem_reg   <= '0;
        end
        else if (cmd.step)
        begin
            tx_rem_reg <= slbs_pkg::rem_digits(tx_rem_reg,
                tx_shift_reg[slbs_pkg::DIV_W-1 -: slbs_pkg::DIGIT_BITS], align_reg);
            rx_rem_reg <= slbs_pkg::rem_digits(rx_rem_reg,
                rx_shift_reg[slbs_pkg::DIV_W-1 -: slbs_pkg::DIGIT_BITS], align_reg);
            tx_shift_reg <= tx_shift_reg << slbs_pkg::DIGIT_BITS;
            rx_shift_reg <= rx_shift_reg << slbs_pkg::DIGIT_BITS;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            o_cmd_reg      <= cmd_word_reg;
            o_len_reg      <= len_word_reg;
            o_tx_dma_reg   <= tx_dma_next;
            o_rx_dma_reg   <= rx_dma_next;
            o_tx_frame_reg <= tx_frame_reg;
            o_rx_frame_reg <= rx_frame_reg;
            o_first_reg    <= first_reg;
            o_eot_reg      <= eot_reg;
            o_tx_err_reg   <= tx_err_reg;
            o_ind_err_reg  <= ind_err_reg;
            o_rx_err_reg   <= rx_err_reg;
        end
    end

    assign m_tdata = {{slbs_pkg::OUT_PAD_W{1'b0}}, o_rx_frame_reg, o_tx_frame_reg,
                      o_rx_dma_reg, o_tx_dma_reg, o_len_reg, o_cmd_reg};
    assign m_tuser = {o_rx_err_reg, o_ind_err_reg, o_tx_err_reg, o_first_reg};
    assign m_tlast = o_eot_reg;

endmodule

// ===== hw/rtl/spi_link_burst_sequencer.sv =====
// ----------------------------------------------------------------------------
// spi_link_burst_sequencer
// master-side burst sequencer of a framed serial link
// ----------------------------------------------------------------------------
// s_* : one beat per burst: next transmit length, slave indication word and
//       the receive length the slave announced in that burst
// m_* : one beat per burst: command word, length word, both dma lengths and
//       the committed frame lengths carried; flags in tuser, tlast on end
// cfg_* : register writes, always accepted; write only with no burst in flight
// timing: the command is chosen as the beat is taken, the alignment
//   remainders are worked out six bits a cycle, then the last state pads and
//   loads the result into the output register, which offers the result beat;
//   the next beat is taken the cycle after the load and never before it
// reset: link closed with a read owed, lengths zero, registers at defaults
// stalls: a finished result waits in the output register; one new beat is
//   still taken and worked on, and only its load waits for m_tready
// ----------------------------------------------------------------------------
module spi_link_burst_sequencer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // tx_next_len[15:0], slave_cmd[31:16], slave_len[47:32]
    input  logic [slbs_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // command_word[15:0], length_word[31:16], tx_dma_bytes[48:32],
    // rx_dma_bytes[65:49], tx_frame_len[81:66], rx_frame_len[97:82], zero above
    output logic [slbs_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // first_burst[0], tx_len_error[1], indication_error[2], rx_len_error[3]
    output logic [slbs_pkg::OUT_TUSER_W-1:0]     m_tuser,
    // end_of_transfer
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // register write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [slbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [slbs_pkg::WORD_W-1:0]          cfg_data
);

    slbs_pkg::dp_cmd_t    dp_cmd;
    slbs_pkg::dp_status_t dp_status;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    slbs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    slbs_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// spi link burst sequencer testbench
// drives bursts on the input stream and register writes on the config
// channel, predicts every result beat from its own model of the sequencer
// state and compares each output beat field by field; a short directed table
// opens the run, then random transfers under several register settings
// ----------------------------------------------------------------------------
module testbench;

    import slbs_pkg::*;

    // run length and pacing
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 250;
    localparam int PHASE_BURSTS = 165;
    localparam int PHASES       = 6;
    localparam int SETTLE       = 8;

    // top of the register index space, indexes above CFG_INDICATION_CODE are unused
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

    // one result beat, fields as they sit on the output stream
    typedef struct packed {
        logic [WORD_W-1:0]    command;
        logic [WORD_W-1:0]    length;
        logic [DMA_W-1:0]     tx_dma;
        logic [DMA_W-1:0]     rx_dma;
        logic [WORD_W-1:0]    tx_frame;
        logic [WORD_W-1:0]    rx_frame;
        logic                 first;
        logic                 eot;
        logic                 tx_err;
        logic                 ind_err;
        logic                 rx_err;
        logic [OUT_PAD_W-1:0] fill;
    } burst_report_t;

    typedef enum logic { ROW_BURST, ROW_REG } row_kind_t;

    // one line of the directed table: a burst, or a register write
    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [WORD_W-1:0]    reg_value;
        logic [WORD_W-1:0]    tx_next;
        logic [WORD_W-1:0]    slave_cmd;
        logic [WORD_W-1:0]    slave_len;
        burst_report_t        typed;
    } table_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic [IN_TDATA_W-1:0]    s_tdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic [OUT_TUSER_W-1:0]   m_tuser;
    logic                     m_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [WORD_W-1:0]        cfg_data;

    // register shadow
    logic [ALIGN_W-1:0]       align_cfg;
    logic [WORD_W-1:0]        write_cmd;
    logic [WORD_W-1:0]        read_cmd;
    logic [WORD_W-1:0]        end_cmd;
    logic [WORD_W-1:0]        ind_cmd;

    // link state as the sequencer should hold it
    logic                     link_closed;
    logic                     read_pending;
    logic [WORD_W-1:0]        tx_held;
    logic [WORD_W-1:0]        rx_held;
    logic [WORD_W-1:0]        rx_promised;

    burst_report_t            awaited_reports[$];
    table_row_t               directed_rows[$];
    int                       mismatches   = 0;
    int                       reports_seen = 0;
    int                       cycle_count  = 0;
    int                       beats_left   = 0;
    logic                     hold_done    = 1'b0;

    spi_link_burst_sequencer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // dma length: frame plus overhead, rounded up to the alignment only when a
    // frame is carried; an alignment of zero behaves as one
    function automatic logic [DMA_W-1:0] pad_dma(input logic [WORD_W-1:0] frame,
                                                 input int overhead);
        int unit;
        int total;
        int rest;
        unit  = (align_cfg == 0) ? 1 : int'(align_cfg);
        total = int'(frame) + overhead;
        rest  = total % unit;
        if (frame != 0 && rest != 0)
        begin
            total = total + unit - rest;
        end
        return total[DMA_W-1:0];
    endfunction

    // one burst through the sequencer: picks the trailing command, reports the
    // lengths carried and moves the link state on
    function automatic burst_report_t sequence_burst(input logic [WORD_W-1:0] tx_next,
                                                     input logic [WORD_W-1:0] slave_cmd,
                                                     input logic [WORD_W-1:0] slave_len);
        burst_report_t r;
        r = '0;
        r.first = link_closed;
        // a closed link opens on any burst, with a read owed
        if (link_closed)
        begin
            link_closed  = 1'b0;
            read_pending = 1'b1;
        end
        if (tx_next != 0)
        begin
            r.command    = write_cmd;
            read_pending = 1'b1;
        end
        else if (rx_promised != 0 || read_pending)
        begin
            r.command    = read_cmd;
            read_pending = 1'b0;
        end
        else
        begin
            r.command = end_cmd;
            r.eot     = 1'b1;
        end
        r.length   = tx_next;
        r.tx_dma   = pad_dma(tx_held, CMD_BYTES);
        r.rx_dma   = pad_dma(rx_held, IND_BYTES);
        r.tx_frame = tx_held;
        r.rx_frame = rx_held;
        r.tx_err   = (int'(tx_next) > BUFFER_BYTES);
        r.ind_err  = (slave_cmd != ind_cmd);
        r.rx_err   = (int'(rx_held) > BUFFER_BYTES);
        // a bad indication is only flagged, its length still counts
        rx_promised = slave_len;
        if (r.eot)
        begin
            link_closed = 1'b1;
            tx_held     = '0;
            rx_held     = '0;
        end
        else
        begin
            tx_held = tx_next;
            rx_held = slave_len;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        burst_report_t want;
        burst_report_t got;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            reports_seen++;
            got.command  = m_tdata[15:0];
            got.length   = m_tdata[31:16];
            got.tx_dma   = m_tdata[48:32];
            got.rx_dma   = m_tdata[65:49];
            got.tx_frame = m_tdata[81:66];
            got.rx_frame = m_tdata[97:82];
            got.fill     = m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W];
            got.first    = m_tuser[0];
            got.tx_err   = m_tuser[1];
            got.ind_err  = m_tuser[2];
            got.rx_err   = m_tuser[3];
            got.eot      = m_tlast;
            if (awaited_reports.size() == 0)
            begin
                $display("%0t: result beat with none expected, expected nothing, actual %0h",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                compare_field("command_word", 32'(want.command), 32'(got.command));
                compare_field("length_word", 32'(want.length), 32'(got.length));
                compare_field("tx_dma_bytes", 32'(want.tx_dma), 32'(got.tx_dma));
                compare_field("rx_dma_bytes", 32'(want.rx_dma), 32'(got.rx_dma));
                compare_field("tx_frame_len", 32'(want.tx_frame), 32'(got.tx_frame));
                compare_field("rx_frame_len", 32'(want.rx_frame), 32'(got.rx_frame));
                compare_field("tdata fill", 32'(want.fill), 32'(got.fill));
                compare_field("first_burst", 32'(want.first), 32'(got.first));
                compare_field("end_of_transfer", 32'(want.eot), 32'(got.eot));
                compare_field("tx_len_error", 32'(want.tx_err), 32'(got.tx_err));
                compare_field("indication_error", 32'(want.ind_err), 32'(got.ind_err));
                compare_field("rx_len_error", 32'(want.rx_err), 32'(got.rx_err));
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: ready pattern of its own, with one long hold-off so that the
    // output register fills and the input stream backs up
    // ------------------------------------------------------------------------

    initial
    begin : ready_pattern
        int pick;
        int span;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!hold_done && reports_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                @(negedge clk) m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 9);
                span = $urandom_range(1, 24);
                repeat (span)
                begin
                    @(negedge clk);
                    if (pick < 4)
                        m_tready <= 1'b1;
                    else if (pick < 8)
                        m_tready <= ($urandom_range(0, 3) != 0);
                    else
                        m_tready <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // drop valid for a number of cycles
    task automatic pause_input(input int cycles);
        @(negedge clk) s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // offer one burst beat, in bursts of random length with random gaps;
    // typed fields of a directed row stand in for the predicted ones
    task automatic send_burst(input logic [WORD_W-1:0] tx_next,
                              input logic [WORD_W-1:0] slave_cmd,
                              input logic [WORD_W-1:0] slave_len,
                              input logic pinned, input burst_report_t typed);
        burst_report_t r;
        if (beats_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                pause_input($urandom_range(1, 10));
            beats_left = $urandom_range(1, 16);
        end
        beats_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {slave_len, slave_cmd, tx_next};
        do @(posedge clk); while (s_tready !== 1'b1);
        r = sequence_burst(tx_next, slave_cmd, slave_len);
        if (pinned)
        begin
            r.command = typed.command;
            r.first   = typed.first;
            r.eot     = typed.eot;
            r.tx_err  = typed.tx_err;
            r.ind_err = typed.ind_err;
            r.rx_err  = typed.rx_err;
        end
        awaited_reports.push_back(r);
    endtask

    task automatic send_plain(input logic [WORD_W-1:0] tx_next,
                              input logic [WORD_W-1:0] slave_cmd,
                              input logic [WORD_W-1:0] slave_len);
        send_burst(tx_next, slave_cmd, slave_len, 1'b0, '0);
    endtask

    // stop offering and let every awaited beat come back
    task automatic drain_link;
        pause_input(1);
        while (awaited_reports.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [WORD_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (index)
            CFG_FRAME_ALIGN:     align_cfg = value[ALIGN_W-1:0];
            CFG_WRITE_CODE:      write_cmd = value;
            CFG_READ_CODE:       read_cmd  = value;
            CFG_END_CODE:        end_cmd   = value;
            CFG_INDICATION_CODE: ind_cmd   = value;
            default: ;
        endcase
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // random stimulus
    // ------------------------------------------------------------------------

    // mostly short frames, some around the buffer limit, some anywhere
    function automatic logic [WORD_W-1:0] pick_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 30)
            return '0;
        else if (p < 75)
            return WORD_W'($urandom_range(1, 64));
        else if (p < 85)
            return WORD_W'($urandom_range(BUFFER_BYTES - 2, BUFFER_BYTES + 2));
        else
            return WORD_W'($urandom);
    endfunction

    function automatic logic [WORD_W-1:0] pick_indication();
        if ($urandom_range(0, 9) == 0)
            return WORD_W'($urandom);
        return ind_cmd;
    endfunction

    function automatic logic [WORD_W-1:0] pick_code();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return '0;
        else if (p == 1)
            return '1;
        else
            return WORD_W'($urandom);
    endfunction

    // new register setting for a random phase, extremes of the alignment first
    task automatic set_phase(input int phase);
        logic [ALIGN_W-1:0] align;
        logic [WORD_W-1:0]  word;
        case (phase)
            0:       align = '0;
            1:       align = '1;
            2:       align = 5'd1;
            3:       align = 5'd16;
            default: align = ALIGN_W'($urandom_range(0, 31));
        endcase
        // upper bits of the alignment write carry noise
        word = WORD_W'($urandom);
        word[ALIGN_W-1:0] = align;
        write_reg(CFG_FRAME_ALIGN, word);
        write_reg(CFG_WRITE_CODE, pick_code());
        write_reg(CFG_READ_CODE, pick_code());
        write_reg(CFG_END_CODE, pick_code());
        write_reg(CFG_INDICATION_CODE, pick_code());
        // a write to an unused index must change nothing
        write_reg(CFG_IDX_W'($urandom_range(CFG_INDICATION_CODE + 1, CFG_IDX_TOP)),
                  WORD_W'($urandom));
    endtask

    // a well-formed transfer: writes, reads while the slave announces data,
    // then two empty bursts, which always reach the end command
    task automatic run_transfer(output int sent);
        int writes;
        int reads;
        writes = $urandom_range(0, 5);
        reads  = $urandom_range(0, 3);
        sent   = writes + reads + 2;
        repeat (writes)
            send_plain(pick_len() | WORD_W'($urandom_range(0, 1)), pick_indication(),
                       pick_len());
        repeat (reads)
            send_plain('0, pick_indication(), pick_len());
        repeat (2)
            send_plain('0, pick_indication(), '0);
    endtask

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------

    task automatic add_burst_row(input logic [WORD_W-1:0] tx_next,
                                 input logic [WORD_W-1:0] slave_cmd,
                                 input logic [WORD_W-1:0] slave_len,
                                 input logic [WORD_W-1:0] command,
                                 input int first, input int eot,
                                 input int tx_err, input int ind_err,
                                 input int rx_err);
        table_row_t row;
        row = '0;
        row.kind          = ROW_BURST;
        row.tx_next       = tx_next;
        row.slave_cmd     = slave_cmd;
        row.slave_len     = slave_len;
        row.typed.command = command;
        row.typed.first   = (first != 0);
        row.typed.eot     = (eot != 0);
        row.typed.tx_err  = (tx_err != 0);
        row.typed.ind_err = (ind_err != 0);
        row.typed.rx_err  = (rx_err != 0);
        directed_rows.push_back(row);
    endtask

    task automatic add_reg_row(input logic [CFG_IDX_W-1:0] index,
                               input logic [WORD_W-1:0] value);
        table_row_t row;
        row = '0;
        row.kind      = ROW_REG;
        row.reg_index = index;
        row.reg_value = value;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin : main_sequence
        table_row_t row;
        int         phase_sent;
        int         sent;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FRAME_ALIGN;
        cfg_data  = '0;

        align_cfg    = FRAME_ALIGN_RST;
        write_cmd    = WRITE_CODE_RST;
        read_cmd     = READ_CODE_RST;
        end_cmd      = END_CODE_RST;
        ind_cmd      = INDICATION_CODE_RST;
        link_closed  = 1'b1;
        read_pending = 1'b1;
        tx_held      = '0;
        rx_held      = '0;
        rx_promised  = '0;

        // register defaults: write 0, read 1, end 2, indication 4
        // opening burst with nothing pending takes the owed read, next one ends
        add_burst_row(16'h0000, 16'h0004, 16'h0000, 16'h0001, 1, 0, 0, 0, 0);
        add_burst_row(16'h0000, 16'h0004, 16'h0000, 16'h0002, 0, 1, 0, 0, 0);
        // all-ones burst: write, oversize length, bad indication
        add_burst_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1, 0, 1, 1, 0);
        // announced length forces a read, committed receive length is oversize
        add_burst_row(16'h0000, 16'h0004, 16'h0000, 16'h0001, 0, 0, 0, 0, 1);
        add_burst_row(16'h0000, 16'h0004, 16'h0000, 16'h0002, 0, 1, 0, 0, 0);
        // exactly at the buffer limit, then one past it
        add_burst_row(16'd8192, 16'h0004, 16'd8193, 16'h0000, 1, 0, 0, 0, 0);
        add_burst_row(16'd8193, 16'h0000, 16'd5,    16'h0000, 0, 0, 1, 1, 1);
        add_burst_row(16'h0000, 16'h0004, 16'h0000, 16'h0001, 0, 0, 0, 0, 0);
        add_burst_row(16'h0000, 16'h0004, 16'h0000, 16'h0002, 0, 1, 0, 0, 0);
        // alignment zero behaves as one, extreme command codes
        add_reg_row(CFG_FRAME_ALIGN, 16'h0000);
        add_reg_row(CFG_WRITE_CODE, 16'hFFFF);
        add_reg_row(CFG_READ_CODE, 16'h0000);
        add_reg_row(CFG_END_CODE, 16'h8001);
        add_reg_row(CFG_INDICATION_CODE, 16'hFFFF);
        add_burst_row(16'd3,    16'hFFFF, 16'd1,    16'hFFFF, 1, 0, 0, 0, 0);
        add_burst_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 1, 0);
        add_burst_row(16'h0000, 16'hFFFF, 16'h0000, 16'h8001, 0, 1, 0, 0, 0);
        // largest alignment the five-bit field holds
        add_reg_row(CFG_FRAME_ALIGN, 16'h001F);
        add_burst_row(16'd1,    16'hFFFF, 16'd2,    16'hFFFF, 1, 0, 0, 0, 0);
        add_burst_row(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        add_burst_row(16'h0000, 16'hFFFF, 16'h0000, 16'h8001, 0, 1, 0, 0, 0);
        // alignment sixteen with the largest lengths
        add_reg_row(CFG_FRAME_ALIGN, 16'h0010);
        add_burst_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 1, 0, 0);
        add_burst_row(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 0, 0, 0, 0, 1);
        add_burst_row(16'h0000, 16'hFFFF, 16'h0000, 16'h8001, 0, 1, 0, 0, 0);
        // alignment one, a transfer with nothing to move
        add_reg_row(CFG_FRAME_ALIGN, 16'h0001);
        add_burst_row(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1, 0, 0, 0, 0);
        add_burst_row(16'h0000, 16'hFFFF, 16'h0000, 16'h8001, 0, 1, 0, 0, 0);

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
            begin
                drain_link();
                write_reg(row.reg_index, row.reg_value);
            end
            else
            begin
                send_burst(row.tx_next, row.slave_cmd, row.slave_len, 1'b1, row.typed);
            end
        end

        // random phases, each under a fresh register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_link();
            set_phase(phase);
            phase_sent = 0;
            while (phase_sent < PHASE_BURSTS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: any burst at all, possibly mid-transfer
                    send_plain(WORD_W'($urandom), WORD_W'($urandom), WORD_W'($urandom));
                    phase_sent++;
                end
                else
                begin
                    run_transfer(sent);
                    phase_sent += sent;
                end
                // now and then wait for the link to run empty
                if ($urandom_range(0, 24) == 0)
                    drain_link();
            end
        end

        drain_link();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && awaited_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/slbs_pkg.sv
hw/rtl/slbs_ctrl.sv
hw/rtl/slbs_datapath.sv
hw/rtl/spi_link_burst_sequencer.sv
dv/testbench.sv
